>>> sv/ppfm_pkg.sv
// Shared types and constants for the projective pixel forward map.
// No dependencies; imported by every module of the block.
`default_nettype none
package ppfm_pkg;

  localparam int COEF_W     = 32;
  localparam int PERSP_W    = 40;
  localparam int COORD_W    = 9;
  localparam int PIX_W      = 8;
  // |X * 2^16| < 2^58 and |Z| < 2^50 for 9-bit source coordinates
  localparam int NUM_W      = 59;
  localparam int DEN_W      = 51;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 40;

  localparam logic [CFG_IDX_W-1:0] REG_M00       = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_M01       = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_M02       = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_M10       = 8'd3;
  localparam logic [CFG_IDX_W-1:0] REG_M11       = 8'd4;
  localparam logic [CFG_IDX_W-1:0] REG_M12       = 8'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PERSP_ROW = 8'd6;
  localparam logic [CFG_IDX_W-1:0] REG_PERSP_COL = 8'd7;

  typedef struct packed {
    logic signed [COEF_W-1:0]  m00;
    logic signed [COEF_W-1:0]  m01;
    logic signed [COEF_W-1:0]  m02;
    logic signed [COEF_W-1:0]  m10;
    logic signed [COEF_W-1:0]  m11;
    logic signed [COEF_W-1:0]  m12;
    logic signed [PERSP_W-1:0] persp_row;
    logic signed [PERSP_W-1:0] persp_col;
  } coef_t;

  typedef struct packed {
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] red;
  } pixel_t;

  // Classified item handed from front to back: magnitudes and signs
  typedef struct packed {
    logic [NUM_W-1:0] num_x;
    logic [NUM_W-1:0] num_y;
    logic [DEN_W-1:0] den;
    logic             neg_x;
    logic             neg_y;
    logic             drop;
    pixel_t           pix;
  } item_t;

endpackage
`default_nettype wire

>>> sv/ppfm_front.sv
// Front end: homogeneous coordinates and classification of one pixel.
// Depends on ppfm_pkg.
`default_nettype none
module ppfm_front import ppfm_pkg::*; #(
  parameter int QW = 10
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               accept,
  input  wire logic [COORD_W-1:0] row,
  input  wire logic [COORD_W-1:0] col,
  input  wire pixel_t             pix,
  input  wire coef_t              coef,
  output logic                    push,
  output item_t                   item
);

  logic signed [COORD_W:0] r_s, c_s;
  assign r_s = $signed({1'b0, row});
  assign c_s = $signed({1'b0, col});

  // stage 1: products
  logic                             v1;
  logic signed [COEF_W+COORD_W:0]   px_r, px_c, py_r, py_c;
  logic signed [PERSP_W+COORD_W:0]  pz_r, pz_c;
  pixel_t                           pix1;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else     v1 <= accept;
    px_r <= coef.m00 * r_s;
    px_c <= coef.m01 * c_s;
    py_r <= coef.m10 * r_s;
    py_c <= coef.m11 * c_s;
    pz_r <= coef.persp_row * r_s;
    pz_c <= coef.persp_col * c_s;
    pix1 <= pix;
  end

  // stage 2: sums
  logic               v2;
  logic signed [63:0] x, y, z;
  pixel_t             pix2;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else     v2 <= v1;
    x    <= 64'(px_r) + 64'(px_c) + 64'(coef.m02);
    y    <= 64'(py_r) + 64'(py_c) + 64'(coef.m12);
    z    <= 64'(pz_r) + 64'(pz_c) + 64'sd4294967296;
    pix2 <= pix1;
  end

  // stage 3: magnitudes, signs, quotient range check
  logic signed [63:0] xs, ys;
  logic [63:0]        ux, uy, uz;
  logic               big_x, big_y;

  always_comb begin
    xs    = x <<< 16;
    ys    = y <<< 16;
    ux    = xs[63] ? 64'(-xs) : 64'(xs);
    uy    = ys[63] ? 64'(-ys) : 64'(ys);
    uz    = z[63]  ? 64'(-z)  : 64'(z);
    big_x = {{QW{1'b0}}, ux} >= {uz, {QW{1'b0}}};
    big_y = {{QW{1'b0}}, uy} >= {uz, {QW{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (rst) push <= 1'b0;
    else     push <= v2;
    item.num_x <= ux[NUM_W-1:0];
    item.num_y <= uy[NUM_W-1:0];
    item.den   <= uz[DEN_W-1:0];
    item.neg_x <= xs[63] ^ z[63];
    item.neg_y <= ys[63] ^ z[63];
    item.drop  <= (z == 64'sd0) || big_x || big_y;
    item.pix   <= pix2;
  end

endmodule
`default_nettype wire

>>> sv/ppfm_queue.sv
// Two-entry queue between the front and back ends.
// Depends on ppfm_pkg.
`default_nettype none
module ppfm_queue import ppfm_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire item_t wr_item,
  input  wire logic  pop,
  output logic       valid,
  output item_t      rd_item,
  output logic       full
);

  item_t      mem [0:1];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       do_push, do_pop;

  assign do_push = push && (count != 2'd2);
  assign do_pop  = pop && (count != 2'd0);
  assign valid   = (count != 2'd0);
  assign full    = (count == 2'd2);
  assign rd_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= wr_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop)  rd_ptr <= ~rd_ptr;
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule
`default_nettype wire

>>> sv/ppfm_back.sv
// Back end: pipelined restoring divider, one quotient bit per stage,
// followed by the image bounds check. Depends on ppfm_pkg.
`default_nettype none
module ppfm_back import ppfm_pkg::*; #(
  parameter int QW   = 10,
  parameter int ROWS = 512,
  parameter int COLS = 512
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  input  wire item_t         in_item,
  output logic               res_valid,
  output logic [COORD_W-1:0] res_row,
  output logic [COORD_W-1:0] res_col,
  output pixel_t             res_pix
);

  localparam int CW = NUM_W + QW;

  typedef struct packed {
    logic [NUM_W-1:0] rx;
    logic [NUM_W-1:0] ry;
    logic [QW-1:0]    qx;
    logic [QW-1:0]    qy;
    logic [DEN_W-1:0] den;
    logic             neg_x;
    logic             neg_y;
    logic             drop;
    pixel_t           pix;
  } stage_t;

  stage_t st  [0:QW];
  logic   vld [0:QW];

  always_comb begin
    vld[0]      = in_valid;
    st[0].rx    = in_item.num_x;
    st[0].ry    = in_item.num_y;
    st[0].qx    = '0;
    st[0].qy    = '0;
    st[0].den   = in_item.den;
    st[0].neg_x = in_item.neg_x;
    st[0].neg_y = in_item.neg_y;
    st[0].drop  = in_item.drop;
    st[0].pix   = in_item.pix;
  end

  for (genvar s = 1; s <= QW; s++) begin : g_step
    localparam int K = QW - s;
    logic [CW-1:0] dsh;
    logic          fx, fy;
    stage_t        st_next;

    always_comb begin
      dsh     = CW'(st[s-1].den) << K;
      fx      = CW'(st[s-1].rx) >= dsh;
      fy      = CW'(st[s-1].ry) >= dsh;
      st_next = st[s-1];
      if (fx) begin
        st_next.rx    = NUM_W'(CW'(st[s-1].rx) - dsh);
        st_next.qx[K] = 1'b1;
      end
      if (fy) begin
        st_next.ry    = NUM_W'(CW'(st[s-1].ry) - dsh);
        st_next.qy[K] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) vld[s] <= 1'b0;
      else     vld[s] <= vld[s-1];
      st[s] <= st_next;
    end
  end

  logic keep;
  always_comb begin
    keep = vld[QW] && !st[QW].drop
        && !((st[QW].qx != '0) && st[QW].neg_x)
        && !((st[QW].qy != '0) && st[QW].neg_y)
        && (32'(st[QW].qx) < 32'(ROWS))
        && (32'(st[QW].qy) < 32'(COLS));
  end

  always_ff @(posedge clk) begin
    if (rst) res_valid <= 1'b0;
    else     res_valid <= keep;
    res_row <= COORD_W'(st[QW].qx);
    res_col <= COORD_W'(st[QW].qy);
    res_pix <= st[QW].pix;
  end

endmodule
`default_nettype wire

>>> sv/projective_pixel_forward_map.sv
// Projective pixel forward map: top level, register file and wiring.
// Path from start to result: front stages, queue, one-bit-per-stage divider
// and the result register. Throughput: one pixel per cycle.
// The receiver cannot stall; busy stays low in operation.
// Synchronous reset clears the pipeline and loads the identity matrix.
// Depends on ppfm_pkg, ppfm_front, ppfm_queue, ppfm_back.
`default_nettype none
module projective_pixel_forward_map import ppfm_pkg::*; #(
  parameter int ROWS = 512,
  parameter int COLS = 512
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // pixel command
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [COORD_W-1:0]    src_row,
  input  wire logic [COORD_W-1:0]    src_col,
  input  wire logic [PIX_W-1:0]      in_blue,
  input  wire logic [PIX_W-1:0]      in_green,
  input  wire logic [PIX_W-1:0]      in_red,
  // result, each beat valid for a single cycle
  output logic                       result_valid,
  output logic [COORD_W-1:0]         dst_row,
  output logic [COORD_W-1:0]         dst_col,
  output logic [PIX_W-1:0]           out_blue,
  output logic [PIX_W-1:0]           out_green,
  output logic [PIX_W-1:0]           out_red,
  // configuration writes
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  // quotient bits: enough to hold any in-range coordinate plus one
  localparam int MAXD = (ROWS > COLS) ? ROWS : COLS;
  localparam int QW   = $clog2(MAXD) + 1;

  coef_t  coef;
  pixel_t in_pix, res_pix;
  logic   accept;

  // Register file: always ready, write the addressed register, ignore the rest.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef.m00       <= 32'sd65536;
      coef.m01       <= '0;
      coef.m02       <= '0;
      coef.m10       <= '0;
      coef.m11       <= 32'sd65536;
      coef.m12       <= '0;
      coef.persp_row <= '0;
      coef.persp_col <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_M00:       coef.m00       <= cfg_data[COEF_W-1:0];
        REG_M01:       coef.m01       <= cfg_data[COEF_W-1:0];
        REG_M02:       coef.m02       <= cfg_data[COEF_W-1:0];
        REG_M10:       coef.m10       <= cfg_data[COEF_W-1:0];
        REG_M11:       coef.m11       <= cfg_data[COEF_W-1:0];
        REG_M12:       coef.m12       <= cfg_data[COEF_W-1:0];
        REG_PERSP_ROW: coef.persp_row <= cfg_data[PERSP_W-1:0];
        REG_PERSP_COL: coef.persp_col <= cfg_data[PERSP_W-1:0];
        default: ;
      endcase
    end
  end

  assign accept       = start && !busy;
  assign in_pix.blue  = in_blue;
  assign in_pix.green = in_green;
  assign in_pix.red   = in_red;

  // Front: form X, Y, Z and classify the beat.
  logic  push;
  item_t front_item;

  ppfm_front #(.QW(QW)) u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .row    (src_row),
    .col    (src_col),
    .pix    (in_pix),
    .coef   (coef),
    .push   (push),
    .item   (front_item)
  );

  // Queue: decouple front from back; the back drains one entry each cycle.
  logic  q_valid, q_full;
  item_t q_item;

  ppfm_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_item (front_item),
    .pop     (q_valid),
    .valid   (q_valid),
    .rd_item (q_item),
    .full    (q_full)
  );

  assign busy = q_full;

  // Back: divide, check bounds, drop what falls outside.
  ppfm_back #(.QW(QW), .ROWS(ROWS), .COLS(COLS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (q_valid),
    .in_item   (q_item),
    .res_valid (result_valid),
    .res_row   (dst_row),
    .res_col   (dst_col),
    .res_pix   (res_pix)
  );

  assign out_blue  = res_pix.blue;
  assign out_green = res_pix.green;
  assign out_red   = res_pix.red;

endmodule
`default_nettype wire
